@@ hw/rtl/vfcm_pkg.sv @@
// Shared types, constants and tables for the voxel face culling mesher.
// Used by vfcm_ctrl, vfcm_datapath and voxel_face_cull_mesher; depends on nothing.
package vfcm_pkg;

    localparam int GRID_DIM_DEF = 32;

    localparam int SIZE_W    = 6;
    localparam int COORD_W   = 5;
    localparam int COLOR_W   = 8;
    localparam int POS_W     = 7;
    localparam int FACE_W    = 3;
    localparam int CORNER_W  = 2;
    localparam int VIDX_W    = 20;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int VOXEL_W   = 25;
    localparam int NUM_FACES = 6;
    localparam int VIS_BIT   = 24;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [FACE_W-1:0] FACE_NX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd5;

    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_MESH  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CENTER,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mem_write;
        logic count_clear;
        logic rd_center;
        logic start_scan;
        logic scan_step;
        logic emit_step;
    } ctl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic center_ok;
        logic center_vis;
        logic scan_last;
        logic scan_mask_zero;
        logic mask_empty;
        logic emit_done;
    } ctl_stat_t;

    // Corner codes, four per face: bit 0 is x, bit 1 is y, bit 2 is z.
    localparam logic [2:0] CORNER_TAB [24] = '{
        3'd2, 3'd6, 3'd0, 3'd4,
        3'd7, 3'd3, 3'd5, 3'd1,
        3'd4, 3'd5, 3'd0, 3'd1,
        3'd2, 3'd3, 3'd6, 3'd7,
        3'd3, 3'd2, 3'd1, 3'd0,
        3'd6, 3'd7, 3'd4, 3'd5
    };

    function automatic logic [2:0] corner_code(input logic [FACE_W-1:0] face_sel,
                                               input logic [CORNER_W-1:0] corner_sel);
        logic [4:0] idx;
        idx = {face_sel, corner_sel};
        if (idx < 5'd24)
            return CORNER_TAB[idx];
        else
            return 3'd0;
    endfunction

endpackage

@@ hw/rtl/vfcm_ctrl.sv @@
// Controller state machine of the voxel face culling mesher.
// Depends on vfcm_pkg; drives the datapath through ctl_cmd_t and reads ctl_stat_t.
module vfcm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  vfcm_pkg::ctl_stat_t stat,
    output vfcm_pkg::ctl_cmd_t  cmd
);
    import vfcm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (stat.cmd == CMD_MESH && stat.center_ok)
                    state_next = ST_CENTER;
                else
                    state_next = ST_IDLE;
            end
            ST_CENTER:
            begin
                if (stat.center_vis)
                    state_next = ST_SCAN;
                else
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                    state_next = stat.scan_mask_zero ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.emit_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_DISPATCH:
            begin
                cmd.mem_write   = (stat.cmd == CMD_WRITE) && stat.center_ok;
                cmd.count_clear = (stat.cmd == CMD_CLEAR);
                cmd.rd_center   = (stat.cmd == CMD_MESH) && stat.center_ok;
            end
            ST_CENTER:
            begin
                cmd.start_scan = stat.center_vis;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_has_faces: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !stat.mask_empty)
        else $error("Emitting with no faces left to emit.");

    a_no_work_while_open: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(cmd.emit_step || cmd.scan_step || cmd.start_scan))
        else $error("Input open while a mesh command is in progress.");
`endif

endmodule

@@ hw/rtl/vfcm_datapath.sv @@
// Datapath of the voxel face culling mesher: size registers, voxel memory,
// neighbor scan, vertex generation, vertex counter and output register. Depends on vfcm_pkg.
module vfcm_datapath #(
    parameter int GRID_DIM = vfcm_pkg::GRID_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vfcm_pkg::SIZE_W-1:0]        cfg_data,
    input  logic [vfcm_pkg::CMD_W-1:0]         cmd_in,
    input  logic [vfcm_pkg::COORD_W-1:0]       vox_x,
    input  logic [vfcm_pkg::COORD_W-1:0]       vox_y,
    input  logic [vfcm_pkg::COORD_W-1:0]       vox_z,
    input  logic [vfcm_pkg::COLOR_W-1:0]       in_red,
    input  logic [vfcm_pkg::COLOR_W-1:0]       in_green,
    input  logic [vfcm_pkg::COLOR_W-1:0]       in_blue,
    input  logic                               in_visible,
    input  vfcm_pkg::ctl_cmd_t                 cmd,
    output vfcm_pkg::ctl_stat_t                stat,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vfcm_pkg::POS_W-1:0]  pos_x,
    output logic signed [vfcm_pkg::POS_W-1:0]  pos_y,
    output logic signed [vfcm_pkg::POS_W-1:0]  pos_z,
    output logic [vfcm_pkg::COLOR_W-1:0]       out_red,
    output logic [vfcm_pkg::COLOR_W-1:0]       out_green,
    output logic [vfcm_pkg::COLOR_W-1:0]       out_blue,
    output logic [vfcm_pkg::FACE_W-1:0]        face,
    output logic [vfcm_pkg::VIDX_W-1:0]        vertex_index,
    output logic                               last
);
    import vfcm_pkg::*;

    localparam int CW     = $clog2(GRID_DIM);
    localparam int ADDR_W = 3 * CW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [SIZE_W:0] GD = (SIZE_W+1)'(GRID_DIM);

    logic [SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    cmd_t                cmd_reg;
    logic [COORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [COLOR_W-1:0]  wr_red_reg, wr_green_reg, wr_blue_reg;
    logic                wr_vis_reg;

    logic [VOXEL_W-1:0]  mem [DEPTH];
    logic [VOXEL_W-1:0]  rdata_reg;
    logic                nbr_ok_reg;

    logic [COLOR_W-1:0]  red_reg, green_reg, blue_reg;
    logic [FACE_W-1:0]   scan_idx_reg;
    logic [NUM_FACES-1:0] mask_reg;
    logic [FACE_W-1:0]   face_reg;
    logic [CORNER_W-1:0] corner_reg;
    logic [VIDX_W-1:0]   count_reg;

    logic                out_valid_reg;
    logic [POS_W-1:0]    pos_x_reg, pos_y_reg, pos_z_reg;
    logic [COLOR_W-1:0]  out_red_reg, out_green_reg, out_blue_reg;
    logic [FACE_W-1:0]   out_face_reg;
    logic [VIDX_W-1:0]   out_vidx_reg;
    logic                out_last_reg;

    logic [SIZE_W-1:0]   cx, cy, cz;
    logic [SIZE_W-1:0]   nx, ny, nz;
    logic                nbr_under;
    logic                nbr_ok;
    logic                center_ok;
    logic [FACE_W-1:0]   scan_sel;
    logic [ADDR_W-1:0]   center_addr, nbr_addr, raddr;
    logic                new_bit;
    logic [NUM_FACES-1:0] mask_scan;
    logic [NUM_FACES-1:0] face_onehot;
    logic                face_set;
    logic                last_vtx;
    logic                out_load;
    logic                face_adv;
    logic [2:0]          kcode;
    logic [POS_W-1:0]    px, py, pz;

    function automatic logic in_range(input logic [SIZE_W-1:0] v,
                                      input logic [SIZE_W-1:0] sz);
        return ({1'b0, v} < {1'b0, sz}) && ({1'b0, v} < GD);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIZE_W-1:0] ax,
                                                    input logic [SIZE_W-1:0] ay,
                                                    input logic [SIZE_W-1:0] az);
        return {az[CW-1:0], ay[CW-1:0], ax[CW-1:0]};
    endfunction

    assign cx = {1'b0, x_reg};
    assign cy = {1'b0, y_reg};
    assign cz = {1'b0, z_reg};

    assign center_ok = in_range(cx, size_x_reg) && in_range(cy, size_y_reg)
                       && in_range(cz, size_z_reg);

    assign scan_sel = cmd.start_scan ? FACE_NX : scan_idx_reg + 3'd1;

    always_comb
    begin
        nx        = cx;
        ny        = cy;
        nz        = cz;
        nbr_under = 1'b0;
        unique case (scan_sel)
            FACE_NX:
            begin
                nbr_under = (x_reg == '0);
                nx        = cx - 6'd1;
            end
            FACE_PX: nx = cx + 6'd1;
            FACE_NY:
            begin
                nbr_under = (y_reg == '0);
                ny        = cy - 6'd1;
            end
            FACE_PY: ny = cy + 6'd1;
            FACE_NZ:
            begin
                nbr_under = (z_reg == '0);
                nz        = cz - 6'd1;
            end
            FACE_PZ: nz = cz + 6'd1;
            default: nbr_under = 1'b1;
        endcase
    end

    assign nbr_ok = !nbr_under && in_range(nx, size_x_reg) && in_range(ny, size_y_reg)
                    && in_range(nz, size_z_reg);

    assign center_addr = cell_addr(cx, cy, cz);
    assign nbr_addr    = cell_addr(nx, ny, nz);
    assign raddr       = cmd.rd_center ? center_addr : nbr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_SIZE_X)
                size_x_reg <= cfg_data;
            else if (cfg_index == REG_SIZE_Y)
                size_y_reg <= cfg_data;
            else if (cfg_index == REG_SIZE_Z)
                size_z_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg      <= cmd_t'(cmd_in);
            x_reg        <= vox_x;
            y_reg        <= vox_y;
            z_reg        <= vox_z;
            wr_red_reg   <= in_red;
            wr_green_reg <= in_green;
            wr_blue_reg  <= in_blue;
            wr_vis_reg   <= in_visible;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            mem[center_addr] <= {wr_vis_reg, wr_red_reg, wr_green_reg, wr_blue_reg};
        rdata_reg  <= mem[raddr];
        nbr_ok_reg <= nbr_ok;
    end

    assign new_bit     = !(nbr_ok_reg && rdata_reg[VIS_BIT]);
    assign mask_scan   = mask_reg | (NUM_FACES'(new_bit) << scan_idx_reg);
    assign face_onehot = NUM_FACES'(1) << face_reg;
    assign face_set    = mask_reg[face_reg];
    assign last_vtx    = (corner_reg == CORNER_LAST) && ((mask_reg & ~face_onehot) == '0);
    assign out_load    = cmd.emit_step && face_set && (!out_valid_reg || !out_stall);
    assign face_adv    = cmd.emit_step
                         && (!face_set || (out_load && corner_reg == CORNER_LAST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            mask_reg     <= '0;
            face_reg     <= '0;
            corner_reg   <= '0;
        end
        else if (cmd.start_scan)
        begin
            scan_idx_reg <= '0;
            mask_reg     <= '0;
            face_reg     <= '0;
            corner_reg   <= '0;
        end
        else if (cmd.scan_step)
        begin
            mask_reg <= mask_scan;
            if (scan_idx_reg != FACE_PZ)
                scan_idx_reg <= scan_idx_reg + 3'd1;
        end
        else
        begin
            if (face_adv)
            begin
                mask_reg <= mask_reg & ~face_onehot;
                face_reg <= face_reg + 3'd1;
            end
            if (out_load)
                corner_reg <= corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_scan)
        begin
            red_reg   <= rdata_reg[23:16];
            green_reg <= rdata_reg[15:8];
            blue_reg  <= rdata_reg[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.count_clear)
            count_reg <= '0;
        else if (out_load)
            count_reg <= count_reg + 20'd1;
    end

    assign kcode = corner_code(face_reg, corner_reg);
    assign px = {1'b0, x_reg, 1'b0} + {5'b0, kcode[0], 1'b0} - {1'b0, size_x_reg};
    assign py = {1'b0, y_reg, 1'b0} + {5'b0, kcode[1], 1'b0} - {1'b0, size_y_reg};
    assign pz = {1'b0, z_reg, 1'b0} + {5'b0, kcode[2], 1'b0} - {1'b0, size_z_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_x_reg     <= px;
            pos_y_reg     <= py;
            pos_z_reg     <= pz;
            out_red_reg   <= red_reg;
            out_green_reg <= green_reg;
            out_blue_reg  <= blue_reg;
            out_face_reg  <= face_reg;
            out_vidx_reg  <= count_reg;
            out_last_reg  <= last_vtx;
        end
    end

    assign stat.cmd            = cmd_reg;
    assign stat.center_ok      = center_ok;
    assign stat.center_vis     = rdata_reg[VIS_BIT];
    assign stat.scan_last      = (scan_idx_reg == FACE_PZ);
    assign stat.scan_mask_zero = (mask_scan == '0);
    assign stat.mask_empty     = (mask_reg == '0);
    assign stat.emit_done      = out_load && last_vtx;

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign out_red      = out_red_reg;
    assign out_green    = out_green_reg;
    assign out_blue     = out_blue_reg;
    assign face         = out_face_reg;
    assign vertex_index = out_vidx_reg;
    assign last         = out_last_reg;

`ifndef SYNTHESIS
    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit_step))
        else $error("Output transfer appeared outside vertex emission.");

    a_face_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> (face_reg <= FACE_PZ))
        else $error("Face counter ran past the last face.");
`endif

endmodule

@@ hw/rtl/voxel_face_cull_mesher.sv @@
// Voxel grid face culling mesher: top level joining controller and datapath.
// Depends on vfcm_pkg, vfcm_ctrl and vfcm_datapath.
//
// Usage: commands arrive on the input channel (in_valid/in_stall) with cmd,
// coordinates, color and visibility; a transfer happens when in_valid is high
// and in_stall is low. Write stores one voxel, clear zeroes the vertex
// counter, mesh emits four vertices for each exposed face of a visible voxel
// on the output channel (out_valid/out_stall), with last set on the final one.
// Grid sizes are written through cfg_wr_en/cfg_index/cfg_data while idle.
// Flow: one command at a time. Write and clear pass through the dispatch
// state only. A mesh command passes through the dispatch state, a center
// read state, a scan state that reads the six neighbors (one memory read per
// cycle) and an emit state that gives four vertices per exposed face and
// passes each occluded face before the final exposed one; the next transfer
// is then taken in idle. Within an exposed face the vertex rate is one per
// cycle while the receiver does not stall, through the single output register.
// A stalled receiver holds the output register and pauses emission.
// Reset returns the sizes to 32, zeroes the vertex counter and empties the
// output; voxel memory contents are undefined until written.
module voxel_face_cull_mesher #(
    parameter int GRID_DIM = vfcm_pkg::GRID_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vfcm_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [vfcm_pkg::CMD_W-1:0]         cmd,
    input  logic [vfcm_pkg::COORD_W-1:0]       vox_x,
    input  logic [vfcm_pkg::COORD_W-1:0]       vox_y,
    input  logic [vfcm_pkg::COORD_W-1:0]       vox_z,
    input  logic [vfcm_pkg::COLOR_W-1:0]       in_red,
    input  logic [vfcm_pkg::COLOR_W-1:0]       in_green,
    input  logic [vfcm_pkg::COLOR_W-1:0]       in_blue,
    input  logic                               in_visible,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vfcm_pkg::POS_W-1:0]  pos_x,
    output logic signed [vfcm_pkg::POS_W-1:0]  pos_y,
    output logic signed [vfcm_pkg::POS_W-1:0]  pos_z,
    output logic [vfcm_pkg::COLOR_W-1:0]       out_red,
    output logic [vfcm_pkg::COLOR_W-1:0]       out_green,
    output logic [vfcm_pkg::COLOR_W-1:0]       out_blue,
    output logic [vfcm_pkg::FACE_W-1:0]        face,
    output logic [vfcm_pkg::VIDX_W-1:0]        vertex_index,
    output logic                               last
);
    import vfcm_pkg::*;

    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_stat;

    vfcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    vfcm_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_in       (cmd),
        .vox_x        (vox_x),
        .vox_y        (vox_y),
        .vox_z        (vox_z),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_visible   (in_visible),
        .cmd          (ctl_cmd),
        .stat         (ctl_stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .face         (face),
        .vertex_index (vertex_index),
        .last         (last)
    );

endmodule

@@ test/voxel_face_cull_mesher_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for voxel_face_cull_mesher: predicts every emitted vertex
// and compares each output transfer against the oldest prediction.
// Depends on vfcm_pkg and the voxel_face_cull_mesher RTL.
module voxel_face_cull_mesher_test;
    import vfcm_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int                   DIM        = 32;
    localparam int                   SETTLE     = 40;

    // Corner codes per face: bit 0 is x, bit 1 is y, bit 2 is z.
    localparam logic [2:0] corner_order [24] = '{
        3'd2, 3'd6, 3'd0, 3'd4,
        3'd7, 3'd3, 3'd5, 3'd1,
        3'd4, 3'd5, 3'd0, 3'd1,
        3'd2, 3'd3, 3'd6, 3'd7,
        3'd3, 3'd2, 3'd1, 3'd0,
        3'd6, 3'd7, 3'd4, 3'd5
    };
    localparam int step_x [6] = '{-1, 1, 0, 0, 0, 0};
    localparam int step_y [6] = '{0, 0, -1, 1, 0, 0};
    localparam int step_z [6] = '{0, 0, 0, 0, -1, 1};

    typedef struct {
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   pz;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [FACE_W-1:0]  face;
        logic [VIDX_W-1:0]  index;
        logic               last;
    } vertex_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [SIZE_W-1:0]           cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [CMD_W-1:0]            cmd;
    logic [COORD_W-1:0]          vox_x;
    logic [COORD_W-1:0]          vox_y;
    logic [COORD_W-1:0]          vox_z;
    logic [COLOR_W-1:0]          in_red;
    logic [COLOR_W-1:0]          in_green;
    logic [COLOR_W-1:0]          in_blue;
    logic                        in_visible;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [POS_W-1:0]     pos_x;
    logic signed [POS_W-1:0]     pos_y;
    logic signed [POS_W-1:0]     pos_z;
    logic [COLOR_W-1:0]          out_red;
    logic [COLOR_W-1:0]          out_green;
    logic [COLOR_W-1:0]          out_blue;
    logic [FACE_W-1:0]           face;
    logic [VIDX_W-1:0]           vertex_index;
    logic                        last;

    logic [VOXEL_W-1:0]          cell_word [DIM*DIM*DIM];
    bit                          cell_written [DIM*DIM*DIM];
    logic [SIZE_W-1:0]           ext_x;
    logic [SIZE_W-1:0]           ext_y;
    logic [SIZE_W-1:0]           ext_z;
    logic [VIDX_W-1:0]           vertex_total;
    vertex_t                     pending_vertices [$];

    bit                          sender_idles;
    bit                          receiver_stalls;
    int                          stall_left = 0;
    int                          mismatches = 0;
    int                          items_sent = 0;
    int                          useful_items = 0;
    int                          vertices_checked = 0;
    int                          extents_set = 0;

    voxel_face_cull_mesher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .vox_x        (vox_x),
        .vox_y        (vox_y),
        .vox_z        (vox_z),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_visible   (in_visible),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .face         (face),
        .vertex_index (vertex_index),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int cell_addr(input int x, input int y, input int z);
        return (z * DIM + y) * DIM + x;
    endfunction

    function automatic bit cell_in_grid(input int x, input int y, input int z);
        if (x < 0 || y < 0 || z < 0)
            return 1'b0;
        if (x >= int'(ext_x) || x >= DIM)
            return 1'b0;
        if (y >= int'(ext_y) || y >= DIM)
            return 1'b0;
        if (z >= int'(ext_z) || z >= DIM)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit cell_solid(input int x, input int y, input int z);
        if (!cell_in_grid(x, y, z))
            return 1'b0;
        return cell_word[cell_addr(x, y, z)][VIS_BIT];
    endfunction

    // A mesh is only issued when every voxel it may read has been written.
    function automatic bit mesh_reads_known(input int x, input int y, input int z);
        if (!cell_in_grid(x, y, z))
            return 1'b1;
        if (!cell_written[cell_addr(x, y, z)])
            return 1'b0;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            if (cell_in_grid(x + step_x[f], y + step_y[f], z + step_z[f]) &&
                !cell_written[cell_addr(x + step_x[f], y + step_y[f], z + step_z[f])])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_coord(input logic [SIZE_W-1:0] extent);
        int lim;
        lim = (int'(extent) < DIM) ? int'(extent) : DIM;
        if (lim == 0)
            return $urandom_range(0, DIM - 1);
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 0) ? 0 : lim - 1;
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic void check_field(input string label, input logic [19:0] want,
                                        input logic [19:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Applies one accepted command to the local copy of the grid and queues
    // the vertices it should produce. Returns 1 for a clear or an in-grid write or mesh.
    function automatic bit mesh_vertices(input logic [CMD_W-1:0] c, input int x, input int y,
                                         input int z, input logic [COLOR_W-1:0] r,
                                         input logic [COLOR_W-1:0] g,
                                         input logic [COLOR_W-1:0] b, input logic vis);
        logic [VOXEL_W-1:0] word;
        logic [5:0]         exposed;
        logic [2:0]         code;
        int                 final_face;
        int                 tmp;
        vertex_t            v;
        if (c == CMD_WRITE)
        begin
            if (!cell_in_grid(x, y, z))
                return 1'b0;
            cell_word[cell_addr(x, y, z)] = {vis, r, g, b};
            cell_written[cell_addr(x, y, z)] = 1'b1;
            return 1'b1;
        end
        if (c == CMD_CLEAR)
        begin
            vertex_total = '0;
            return 1'b1;
        end
        if (c != CMD_MESH || !cell_in_grid(x, y, z))
            return 1'b0;
        word = cell_word[cell_addr(x, y, z)];
        if (!word[VIS_BIT])
            return 1'b1;
        final_face = -1;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            exposed[f] = !cell_solid(x + step_x[f], y + step_y[f], z + step_z[f]);
            if (exposed[f])
                final_face = f;
        end
        for (int f = 0; f < NUM_FACES; f++)
        begin
            if (exposed[f])
            begin
                for (int k = 0; k < 4; k++)
                begin
                    code    = corner_order[f * 4 + k];
                    tmp     = 2 * (x + code[0]) - int'(ext_x);
                    v.px    = tmp[POS_W-1:0];
                    tmp     = 2 * (y + code[1]) - int'(ext_y);
                    v.py    = tmp[POS_W-1:0];
                    tmp     = 2 * (z + code[2]) - int'(ext_z);
                    v.pz    = tmp[POS_W-1:0];
                    v.red   = word[23:16];
                    v.green = word[15:8];
                    v.blue  = word[7:0];
                    v.face  = f[FACE_W-1:0];
                    v.index = vertex_total;
                    v.last  = (f == final_face) && (k == 3);
                    pending_vertices = {pending_vertices, v};
                    vertex_total = vertex_total + VIDX_W'(1);
                end
            end
        end
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : vertex_checker
        vertex_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: vertex with no expectation, expected none, got index %0h",
                         $time, vertex_index);
                mismatches++;
            end
            else
            begin
                want = pending_vertices.pop_front();
                check_field("pos_x", 20'(want.px), 20'($unsigned(pos_x)));
                check_field("pos_y", 20'(want.py), 20'($unsigned(pos_y)));
                check_field("pos_z", 20'(want.pz), 20'($unsigned(pos_z)));
                check_field("out_red", 20'(want.red), 20'(out_red));
                check_field("out_green", 20'(want.green), 20'(out_green));
                check_field("out_blue", 20'(want.blue), 20'(out_blue));
                check_field("face", 20'(want.face), 20'(face));
                check_field("vertex_index", want.index, vertex_index);
                check_field("last", 20'(want.last), 20'(last));
                vertices_checked++;
            end
            stall_left = receiver_stalls ? $urandom_range(0, 12) : 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        out_stall <= (stall_left > 0);
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input int x, input int y, input int z,
                             input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b, input logic vis);
        int gap;
        gap = sender_idles ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        vox_x      <= x[COORD_W-1:0];
        vox_y      <= y[COORD_W-1:0];
        vox_z      <= z[COORD_W-1:0];
        in_red     <= r;
        in_green   <= g;
        in_blue    <= b;
        in_visible <= vis;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (mesh_vertices(c, x, y, z, r, g, b, vis))
            useful_items++;
    endtask

    task automatic write_voxel(input int x, input int y, input int z, input logic vis);
        send_item(CMD_WRITE, x, y, z, COLOR_W'($urandom_range(0, 255)),
                  COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)), vis);
    endtask

    task automatic mesh_voxel(input int x, input int y, input int z);
        send_item(CMD_MESH, x, y, z, COLOR_W'($urandom_range(0, 255)),
                  COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_vertices(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_vertices.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_SIZE_X)
            ext_x = data;
        else if (idx == REG_SIZE_Y)
            ext_y = data;
        else if (idx == REG_SIZE_Z)
            ext_z = data;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_extents(input int sx, input int sy, input int sz);
        wait_for_vertices(SETTLE);
        write_reg(REG_SIZE_X, sx[SIZE_W-1:0]);
        write_reg(REG_SIZE_Y, sy[SIZE_W-1:0]);
        write_reg(REG_SIZE_Z, sz[SIZE_W-1:0]);
        @(posedge clk);
        extents_set++;
    endtask

    task automatic test_open_corner();
        send_item(CMD_WRITE, 0, 0, 0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_item(CMD_WRITE, 1, 0, 0, 8'hFF, 8'h00, 8'hFF, 1'b0);
        send_item(CMD_WRITE, 0, 1, 0, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(CMD_WRITE, 0, 0, 1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_item(CMD_MESH, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_far_corner();
        send_item(CMD_WRITE, 31, 31, 31, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        write_voxel(30, 31, 31, 1'b1);
        write_voxel(31, 30, 31, 1'b1);
        write_voxel(31, 31, 30, 1'b1);
        send_item(CMD_MESH, 31, 31, 31, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_counter_clear();
        send_item(CMD_CLEAR, 31, 31, 31, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_NONE, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        mesh_voxel(0, 0, 0);
    endtask

    task automatic test_tiny_grid();
        set_extents(2, 2, 2);
        write_reg(REG_UNUSED, 6'h2A);
        write_voxel(1, 1, 0, 1'b0);
        write_voxel(1, 0, 1, 1'b0);
        write_voxel(0, 1, 1, 1'b1);
        write_voxel(1, 1, 1, 1'b1);
        mesh_voxel(1, 0, 0);
        mesh_voxel(1, 1, 1);
        write_voxel(2, 0, 0, 1'b1);
        mesh_voxel(2, 0, 0);
    endtask

    task automatic test_extent_extremes();
        set_extents(0, 0, 0);
        write_voxel(0, 0, 0, 1'b0);
        mesh_voxel(0, 0, 0);
        set_extents(1, 1, 1);
        mesh_voxel(0, 0, 0);
        set_extents(63, 63, 63);
        mesh_voxel(0, 0, 0);
    endtask

    // Writes the voxel and its neighbors as needed, then meshes it.
    task automatic random_mesh_sequence();
        int x;
        int y;
        int z;
        int nx;
        int ny;
        int nz;
        x = pick_coord(ext_x);
        y = pick_coord(ext_y);
        z = pick_coord(ext_z);
        if (!cell_in_grid(x, y, z) || !cell_written[cell_addr(x, y, z)] ||
            $urandom_range(0, 2) == 0)
            write_voxel(x, y, z, $urandom_range(0, 7) != 0);
        for (int f = 0; f < NUM_FACES; f++)
        begin
            nx = x + step_x[f];
            ny = y + step_y[f];
            nz = z + step_z[f];
            if (cell_in_grid(nx, ny, nz) &&
                (!cell_written[cell_addr(nx, ny, nz)] || $urandom_range(0, 2) == 0))
                write_voxel(nx, ny, nz, 1'($urandom_range(0, 1)));
        end
        mesh_voxel(x, y, z);
    endtask

    task automatic random_noise();
        int x;
        int y;
        int z;
        x = $urandom_range(0, DIM - 1);
        y = $urandom_range(0, DIM - 1);
        z = $urandom_range(0, DIM - 1);
        case ($urandom_range(0, 3))
            0: send_item(CMD_CLEAR, x, y, z, COLOR_W'($urandom_range(0, 255)),
                         COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            1: send_item(CMD_NONE, x, y, z, COLOR_W'($urandom_range(0, 255)),
                         COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            2: write_voxel(x, y, z, 1'($urandom_range(0, 1)));
            default:
            begin
                if (mesh_reads_known(x, y, z))
                    mesh_voxel(x, y, z);
                else
                    write_voxel(x, y, z, 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic test_random_phase(input int sx, input int sy, input int sz, input int count,
                                     input bit idles, input bit stalls);
        int start;
        set_extents(sx, sy, sz);
        sender_idles    = idles;
        receiver_stalls = stalls;
        start = useful_items;
        while (useful_items - start < count)
        begin
            if ($urandom_range(0, 9) < 8)
                random_mesh_sequence();
            else
                random_noise();
            if ($urandom_range(0, 15) == 0)
                wait_for_vertices(0);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = CMD_WRITE;
        vox_x      = '0;
        vox_y      = '0;
        vox_z      = '0;
        in_red     = '0;
        in_green   = '0;
        in_blue    = '0;
        in_visible = 1'b0;
        ext_x        = SIZE_RESET;
        ext_y        = SIZE_RESET;
        ext_z        = SIZE_RESET;
        vertex_total = '0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_open_corner();
        test_far_corner();
        test_counter_clear();
        test_tiny_grid();
        test_extent_extremes();

        test_random_phase(32, 32, 32, 44, 1'b1, 1'b1);
        test_random_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                          44, 1'b0, 1'b0);
        test_random_phase(1, $urandom_range(1, 32), 2, 44, 1'b1, 1'b0);
        test_random_phase(63, $urandom_range(2, 8), 40, 44, 1'b0, 1'b1);
        test_random_phase($urandom_range(2, 6), $urandom_range(2, 6), $urandom_range(2, 6),
                          44, 1'b1, 1'b1);
        test_random_phase($urandom_range(1, 32), $urandom_range(1, 32), $urandom_range(1, 32),
                          44, 1'b1, 1'b1);
        test_random_phase(32, 1, 32, 46, 1'b1, 1'b1);

        wait_for_vertices(SETTLE);
        $display("Sent %0d commands (%0d with effect) over %0d grid extent settings.",
                 items_sent, useful_items, extents_set);
        $display("Checked %0d vertices with %0d mismatches.", vertices_checked, mismatches);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d vertices still expected.", pending_vertices.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
